[hdl/ptc_pkg.sv]
`timescale 1ns / 1ps
// shared constants, register codes and datapath types for the pressure and
// temperature compensation block; no dependencies
package ptc_pkg;

  // pipeline shape
  localparam int NumStages   = 7;
  localparam int FrontStages = 3;
  localparam int BackStages  = NumStages - FrontStages;

  // field and bus widths
  localparam int CalWidth      = 16;
  localparam int RawWidth      = 24;
  localparam int TempWidth     = 19;
  localparam int PresWidth     = 18;
  localparam int AddrWidth     = 5;
  localparam int ApbDataWidth  = 32;
  localparam int InTdataWidth  = 48;
  localparam int OutTdataWidth = 40;

  // calibration register index codes (byte address is 4 * code)
  localparam logic [2:0] RegPresSens    = 3'd0;
  localparam logic [2:0] RegPresOffset  = 3'd1;
  localparam logic [2:0] RegSensTco     = 3'd2;
  localparam logic [2:0] RegOffsetTco   = 3'd3;
  localparam logic [2:0] RegRefTemp     = 3'd4;
  localparam logic [2:0] RegTempSlope   = 3'd5;

  // temperature reference point in hundredths of a degree
  localparam logic signed [19:0] TempRef = 20'sd2000;

  // output saturation limits
  localparam logic [TempWidth-1:0] TempMin = 19'h40000;
  localparam logic [TempWidth-1:0] TempMax = 19'h3FFFF;
  localparam logic [PresWidth-1:0] PresMax = 18'h3FFFF;

  // calibration words
  typedef struct packed {
    logic [CalWidth-1:0] pressure_sensitivity;
    logic [CalWidth-1:0] pressure_offset;
    logic [CalWidth-1:0] sensitivity_temp_coeff;
    logic [CalWidth-1:0] offset_temp_coeff;
    logic [CalWidth-1:0] reference_temperature;
    logic [CalWidth-1:0] temperature_slope;
  } cal_t;

  // one stage-load enable per pipeline stage
  typedef logic [NumStages-1:0] stage_vec_t;

  // scaled terms handed from the front stages to the back stages
  typedef struct packed {
    logic [19:0]         temp_base;   // 2000 + dT*C6/2^23, two's complement
    logic [16:0]         corr_low;    // 3*dT^2/2^33
    logic [12:0]         corr_high;   // 5*dT^2/2^38
    logic [35:0]         offset;      // OFF, two's complement
    logic [34:0]         sens;        // SENS, two's complement
    logic [RawWidth-1:0] raw_p;       // D1
  } scaled_t;

endpackage

[hdl/ptc_cfg.sv]
`timescale 1ns / 1ps
// APB calibration register file, six 16-bit words
// depends on ptc_pkg
module ptc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [ptc_pkg::AddrWidth-1:0]       paddr_i,
  input  logic [ptc_pkg::ApbDataWidth-1:0]    pwdata_i,
  output logic [ptc_pkg::ApbDataWidth-1:0]    prdata_o,
  output logic                                pready_o,
  output ptc_pkg::cal_t                       cal_o
);

  ptc_pkg::cal_t cal_d, cal_q;
  logic          wr_en;
  logic [2:0]    idx;
  logic [ptc_pkg::CalWidth-1:0] rd_word;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;
  assign idx      = paddr_i[ptc_pkg::AddrWidth-1:2];

  // register write decode
  always_comb begin
    cal_d = cal_q;
    if (wr_en) begin
      case (idx)
        ptc_pkg::RegPresSens:   cal_d.pressure_sensitivity   = pwdata_i[15:0];
        ptc_pkg::RegPresOffset: cal_d.pressure_offset        = pwdata_i[15:0];
        ptc_pkg::RegSensTco:    cal_d.sensitivity_temp_coeff = pwdata_i[15:0];
        ptc_pkg::RegOffsetTco:  cal_d.offset_temp_coeff      = pwdata_i[15:0];
        ptc_pkg::RegRefTemp:    cal_d.reference_temperature  = pwdata_i[15:0];
        ptc_pkg::RegTempSlope:  cal_d.temperature_slope      = pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      ptc_pkg::RegPresSens:   rd_word = cal_q.pressure_sensitivity;
      ptc_pkg::RegPresOffset: rd_word = cal_q.pressure_offset;
      ptc_pkg::RegSensTco:    rd_word = cal_q.sensitivity_temp_coeff;
      ptc_pkg::RegOffsetTco:  rd_word = cal_q.offset_temp_coeff;
      ptc_pkg::RegRefTemp:    rd_word = cal_q.reference_temperature;
      ptc_pkg::RegTempSlope:  rd_word = cal_q.temperature_slope;
      default:                rd_word = '0;
    endcase
  end

  assign prdata_o = {16'h0000, rd_word};
  assign cal_o    = cal_q;

endmodule

[hdl/ptc_ctrl.sv]
`timescale 1ns / 1ps
// pipeline occupancy control: per-stage valid bits and load enables
// depends on ptc_pkg
module ptc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output ptc_pkg::stage_vec_t en_o
);

  localparam int N = ptc_pkg::NumStages;

  ptc_pkg::stage_vec_t valid_d, valid_q;
  logic [N:0]          rdy;
  logic                in_acc, out_acc;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[N] = m_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign en_o      = rdy[N-1:0];
  assign s_ready_o = rdy[0];
  assign m_valid_o = valid_q[N-1];
  assign in_acc    = s_valid_i & s_ready_o;
  assign out_acc   = m_valid_o & m_ready_i;

  // valid bits travel with the data
  always_comb begin
    valid_d = valid_q;
    if (rdy[0]) begin
      valid_d[0] = s_valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

`ifndef SYNTHESIS
  // items in flight change only by transfers on the two sides
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(valid_q) ==
             $past($countones(valid_q)) + $past(32'(in_acc)) - $past(32'(out_acc)))
    else $error("pipeline occupancy mismatch");

  // a bubble anywhere means the input side can take an item
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> s_ready_o)
    else $error("input stalled with an empty stage");

  // an accepted item lands in the first stage
  a_first_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> valid_q[0])
    else $error("accepted item lost at first stage");
`endif

endmodule

[hdl/ptc_front.sv]
`timescale 1ns / 1ps
// front stages: dT, the three calibration products and dT squared, and their scaling
// depends on ptc_pkg
module ptc_front (
  input  logic                                 clk_i,
  input  logic [ptc_pkg::FrontStages-1:0]      en_i,
  input  ptc_pkg::cal_t                        cal_i,
  input  logic [ptc_pkg::RawWidth-1:0]         raw_pressure_i,
  input  logic [ptc_pkg::RawWidth-1:0]         raw_temperature_i,
  output ptc_pkg::scaled_t                     scaled_o
);

  localparam logic signed [41:0] Bias23 = (42'sd1 <<< 23) - 42'sd1;
  localparam logic signed [41:0] Bias6  = (42'sd1 <<< 6) - 42'sd1;
  localparam logic signed [41:0] Bias7  = (42'sd1 <<< 7) - 42'sd1;

  // stage 1
  logic signed [24:0]            dt_d, dt_q;
  logic [ptc_pkg::RawWidth-1:0]  p1_q;
  // stage 2
  logic signed [41:0]            mt_d, mt_q, moff_d, moff_q, msens_d, msens_q;
  logic signed [49:0]            sq_full;
  logic [48:0]                   sq_d, sq_q;
  logic [ptc_pkg::RawWidth-1:0]  p2_q;
  // stage 3
  logic signed [41:0]            t_sum, t_sh, o_sum, o_sh, s_sum, s_sh;
  logic [49:0]                   sq3;
  logic [50:0]                   sq5;
  ptc_pkg::scaled_t              sc_d, sc_q;

  // dT = D2 - C5*256
  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cal_i.reference_temperature, 8'h00});

  // calibration products and dT squared
  assign mt_d    = dt_q * $signed({1'b0, cal_i.temperature_slope});
  assign moff_d  = dt_q * $signed({1'b0, cal_i.offset_temp_coeff});
  assign msens_d = dt_q * $signed({1'b0, cal_i.sensitivity_temp_coeff});
  assign sq_full = dt_q * dt_q;
  assign sq_d    = sq_full[48:0];

  // scaling with truncation toward zero
  always_comb begin
    t_sum = mt_q + (mt_q[41] ? Bias23 : 42'sd0);
    t_sh  = t_sum >>> 23;
    o_sum = moff_q + (moff_q[41] ? Bias6 : 42'sd0);
    o_sh  = o_sum >>> 6;
    s_sum = msens_q + (msens_q[41] ? Bias7 : 42'sd0);
    s_sh  = s_sum >>> 7;
    sq3   = {1'b0, sq_q} + {sq_q, 1'b0};
    sq5   = {2'b00, sq_q} + {sq_q, 2'b00};

    sc_d.temp_base = t_sh[19:0] + ptc_pkg::TempRef;
    sc_d.corr_low  = sq3[49:33];
    sc_d.corr_high = sq5[50:38];
    sc_d.offset    = {3'b000, cal_i.pressure_offset, 17'h00000} + o_sh[35:0];
    sc_d.sens      = {3'b000, cal_i.pressure_sensitivity, 16'h0000} + s_sh[34:0];
    sc_d.raw_p     = p2_q;
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dt_q <= dt_d;
      p1_q <= raw_pressure_i;
    end
    if (en_i[1]) begin
      mt_q    <= mt_d;
      moff_q  <= moff_d;
      msens_q <= msens_d;
      sq_q    <= sq_d;
      p2_q    <= p1_q;
    end
    if (en_i[2]) begin
      sc_q <= sc_d;
    end
  end

  assign scaled_o = sc_q;

endmodule

[hdl/ptc_back.sv]
`timescale 1ns / 1ps
// back stages: second-order temperature correction, pressure product,
// scaling, offset removal and saturation; depends on ptc_pkg
module ptc_back (
  input  logic                                 clk_i,
  input  logic [ptc_pkg::BackStages-1:0]       en_i,
  input  ptc_pkg::scaled_t                     scaled_i,
  output logic [ptc_pkg::TempWidth-1:0]        temperature_centi_o,
  output logic [ptc_pkg::PresWidth-1:0]        pressure_pascal_o
);

  localparam logic signed [59:0] Bias21 = (60'sd1 <<< 21) - 60'sd1;

  // stage 4
  logic signed [20:0]               t21;
  logic [ptc_pkg::TempWidth-1:0]    temp4_d, temp4_q, temp5_q, temp6_q, temp7_q;
  logic [40:0]                      pl_d, pl_q;
  logic signed [42:0]               ph_d, ph_q;
  logic [35:0]                      off4_q, off5_q, off6_q;
  // stage 5
  logic signed [59:0]               prod_d, prod_q;
  // stage 6
  logic signed [59:0]               p_sum, p_sh;
  logic signed [38:0]               q_d, q_q;
  // stage 7
  logic signed [39:0]               diff;
  logic [ptc_pkg::PresWidth-1:0]    pres_d, pres_q;

  // second-order correction and temperature saturation
  always_comb begin
    if ($signed(scaled_i.temp_base) < ptc_pkg::TempRef) begin
      t21 = $signed({scaled_i.temp_base[19], scaled_i.temp_base})
          - $signed({4'h0, scaled_i.corr_low});
    end else begin
      t21 = $signed({scaled_i.temp_base[19], scaled_i.temp_base})
          - $signed({8'h00, scaled_i.corr_high});
    end
    if ((t21[20:18] == 3'b000) || (t21[20:18] == 3'b111)) begin
      temp4_d = t21[18:0];
    end else if (t21[20]) begin
      temp4_d = ptc_pkg::TempMin;
    end else begin
      temp4_d = ptc_pkg::TempMax;
    end
  end

  // D1 * SENS as two partial products over the low and high parts of SENS
  assign pl_d = scaled_i.raw_p * scaled_i.sens[16:0];
  assign ph_d = $signed({1'b0, scaled_i.raw_p}) * $signed(scaled_i.sens[34:17]);

  // recombine partial products
  assign prod_d = $signed({ph_q, 17'h00000}) + $signed({19'h00000, pl_q});

  // divide by 2^21 toward zero
  always_comb begin
    p_sum = prod_q + (prod_q[59] ? Bias21 : 60'sd0);
    p_sh  = p_sum >>> 21;
    q_d   = p_sh[38:0];
  end

  // subtract OFF, divide by 2^15 and clamp; a negative difference gives zero
  always_comb begin
    diff = $signed({q_q[38], q_q}) - $signed({{4{off6_q[35]}}, off6_q});
    if (diff[39]) begin
      pres_d = '0;
    end else if (|diff[38:33]) begin
      pres_d = ptc_pkg::PresMax;
    end else begin
      pres_d = diff[32:15];
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      temp4_q <= temp4_d;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      off4_q  <= scaled_i.offset;
    end
    if (en_i[1]) begin
      temp5_q <= temp4_q;
      prod_q  <= prod_d;
      off5_q  <= off4_q;
    end
    if (en_i[2]) begin
      temp6_q <= temp5_q;
      q_q     <= q_d;
      off6_q  <= off5_q;
    end
    if (en_i[3]) begin
      temp7_q <= temp6_q;
      pres_q  <= pres_d;
    end
  end

  assign temperature_centi_o = temp7_q;
  assign pressure_pascal_o   = pres_q;

endmodule

[hdl/pressure_temperature_compensation.sv]
`timescale 1ns / 1ps
// each input transfer passes through every pipeline stage before its result reaches the output side
// throughput: one sample pair per clock while m_axis_tready is high, set by the seven-stage datapath
// a stage refills as soon as it empties, so the output register can hold a
// result while new pairs are still accepted
// reset clears the stage valid bits and all calibration words to zero
module pressure_temperature_compensation (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // calibration register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ptc_pkg::AddrWidth-1:0]         paddr,
  input  logic [ptc_pkg::ApbDataWidth-1:0]      pwdata,
  output logic [ptc_pkg::ApbDataWidth-1:0]      prdata,
  output logic                                  pready,
  // sample input
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ptc_pkg::InTdataWidth-1:0]      s_axis_tdata,  // raw_pressure, raw_temperature
  // result output
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ptc_pkg::OutTdataWidth-1:0]     m_axis_tdata   // temperature_centi,
                                                               // pressure_pascal, zero pad
);

  ptc_pkg::cal_t                    cal;
  ptc_pkg::stage_vec_t              en;
  ptc_pkg::scaled_t                 scaled;
  logic [ptc_pkg::TempWidth-1:0]    temperature_centi;
  logic [ptc_pkg::PresWidth-1:0]    pressure_pascal;

  // calibration registers
  ptc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cal_o     (cal)
  );

  // pipeline control
  ptc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .en_o      (en)
  );

  // dT, products and scaling
  ptc_front u_front (
    .clk_i             (clk_i),
    .en_i              (en[ptc_pkg::FrontStages-1:0]),
    .cal_i             (cal),
    .raw_pressure_i    (s_axis_tdata[23:0]),
    .raw_temperature_i (s_axis_tdata[47:24]),
    .scaled_o          (scaled)
  );

  // corrections, pressure and saturation
  ptc_back u_back (
    .clk_i               (clk_i),
    .en_i                (en[ptc_pkg::NumStages-1:ptc_pkg::FrontStages]),
    .scaled_i            (scaled),
    .temperature_centi_o (temperature_centi),
    .pressure_pascal_o   (pressure_pascal)
  );

  // result packing
  assign m_axis_tdata = {3'b000, pressure_pascal, temperature_centi};

endmodule
